>>> src/shortest_common_supersequence_assert.svh
// assertion macros shared by the supersequence block
`ifndef SHORTEST_COMMON_SUPERSEQUENCE_ASSERT_SVH
`define SHORTEST_COMMON_SUPERSEQUENCE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SCS_ASSERT(lbl, ck, rn, cond) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
    else $error("scs check failed");
`define SCS_ASSERT_IMP(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
    else $error("scs check failed");
`define SCS_ASSERT_NXT(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
    else $error("scs check failed");
`else
`define SCS_ASSERT(lbl, ck, rn, cond)
`define SCS_ASSERT_IMP(lbl, ck, rn, pre, post)
`define SCS_ASSERT_NXT(lbl, ck, rn, pre, post)
`endif
`endif

>>> src/scs_pkg.sv
// shared types, constants and helpers of the supersequence block
package scs_pkg;

  localparam int MAX_LEN_DEF = 32;
  localparam int CHAR_W      = 8;
  localparam int COST_W      = 7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_ROW_RD, ST_ROW_SET, ST_CELL_RD, ST_CELL_WR,
    ST_TB_INIT, ST_TB_CHK, ST_TB_RD2, ST_TB_DEC, ST_TB_TA, ST_TB_TB,
    ST_OUT_INIT, ST_OUT_RD, ST_OUT_LD, ST_OUT_WAIT
  } state_t;

  typedef enum logic [3:0] {
    OP_IDLE, OP_LOAD, OP_START, OP_ROW_SET, OP_CELL_RD, OP_CELL_WR,
    OP_TB_INIT, OP_TB_RD1, OP_TB_RD2, OP_TB_DEC, OP_TB_TA, OP_TB_TB,
    OP_OUT_INIT, OP_OUT_LD, OP_OUT_POP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic row_last;
    logic tab_last;
    logic i_nz;
    logic j_nz;
    logic rptr_zero;
  } sts_t;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

>>> src/scs_ram.sv
// generic single write, single read ram with registered read
module scs_ram #(
  parameter int W = 8,
  parameter int D = 32,
  localparam int AW = scs_pkg::addr_w(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

>>> src/scs_ctrl.sv
// sequencing state machine of the supersequence block
module scs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_end_of_pair,
  output logic          in_stall,
  input  logic          out_stall,
  input  scs_pkg::sts_t sts,
  output scs_pkg::cmd_t cmd
);
  scs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = scs_pkg::OP_IDLE;
    unique case (state_r)
      scs_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.op = scs_pkg::OP_LOAD;
          if (in_end_of_pair) state_nxt = scs_pkg::ST_START;
        end
      end
      scs_pkg::ST_START: begin
        cmd.op    = scs_pkg::OP_START;
        state_nxt = sts.empty ? scs_pkg::ST_TB_INIT : scs_pkg::ST_ROW_RD;
      end
      scs_pkg::ST_ROW_RD:  state_nxt = scs_pkg::ST_ROW_SET;
      scs_pkg::ST_ROW_SET: begin
        cmd.op    = scs_pkg::OP_ROW_SET;
        state_nxt = scs_pkg::ST_CELL_RD;
      end
      scs_pkg::ST_CELL_RD: begin
        cmd.op    = scs_pkg::OP_CELL_RD;
        state_nxt = scs_pkg::ST_CELL_WR;
      end
      scs_pkg::ST_CELL_WR: begin
        cmd.op = scs_pkg::OP_CELL_WR;
        if (!sts.row_last)     state_nxt = scs_pkg::ST_CELL_RD;
        else if (sts.tab_last) state_nxt = scs_pkg::ST_TB_INIT;
        else                   state_nxt = scs_pkg::ST_ROW_RD;
      end
      scs_pkg::ST_TB_INIT: begin
        cmd.op    = scs_pkg::OP_TB_INIT;
        state_nxt = scs_pkg::ST_TB_CHK;
      end
      scs_pkg::ST_TB_CHK: begin
        cmd.op = scs_pkg::OP_TB_RD1;
        priority if (sts.i_nz && sts.j_nz) state_nxt = scs_pkg::ST_TB_RD2;
        else if (sts.i_nz)                 state_nxt = scs_pkg::ST_TB_TA;
        else if (sts.j_nz)                 state_nxt = scs_pkg::ST_TB_TB;
        else                               state_nxt = scs_pkg::ST_OUT_INIT;
      end
      scs_pkg::ST_TB_RD2: begin
        cmd.op    = scs_pkg::OP_TB_RD2;
        state_nxt = scs_pkg::ST_TB_DEC;
      end
      scs_pkg::ST_TB_DEC: begin
        cmd.op    = scs_pkg::OP_TB_DEC;
        state_nxt = scs_pkg::ST_TB_CHK;
      end
      scs_pkg::ST_TB_TA: begin
        cmd.op    = scs_pkg::OP_TB_TA;
        state_nxt = scs_pkg::ST_TB_CHK;
      end
      scs_pkg::ST_TB_TB: begin
        cmd.op    = scs_pkg::OP_TB_TB;
        state_nxt = scs_pkg::ST_TB_CHK;
      end
      scs_pkg::ST_OUT_INIT: begin
        cmd.op    = scs_pkg::OP_OUT_INIT;
        state_nxt = scs_pkg::ST_OUT_RD;
      end
      scs_pkg::ST_OUT_RD: state_nxt = scs_pkg::ST_OUT_LD;
      scs_pkg::ST_OUT_LD: begin
        cmd.op    = scs_pkg::OP_OUT_LD;
        state_nxt = scs_pkg::ST_OUT_WAIT;
      end
      scs_pkg::ST_OUT_WAIT: begin
        if (!out_stall) begin
          cmd.op    = scs_pkg::OP_OUT_POP;
          state_nxt = sts.rptr_zero ? scs_pkg::ST_IDLE : scs_pkg::ST_OUT_RD;
        end
      end
      default: state_nxt = scs_pkg::ST_IDLE;
    endcase
  end

  assign in_stall = (state_r != scs_pkg::ST_IDLE);
endmodule

>>> src/scs_dp.sv
// datapath: string stores, cost table, traceback buffer and output beat
`include "shortest_common_supersequence_assert.svh"
module scs_dp #(
  parameter int MAX_LEN = scs_pkg::MAX_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  scs_pkg::cmd_t              cmd,
  output scs_pkg::sts_t              sts,
  input  logic                       in_opcode,
  input  logic [scs_pkg::CHAR_W-1:0] in_char_in,
  output logic                       out_valid,
  output logic [scs_pkg::CHAR_W-1:0] out_char_out,
  output logic                       out_last,
  output logic                       out_truncated
);
  localparam int CH  = scs_pkg::CHAR_W;
  localparam int CW  = scs_pkg::COST_W;
  localparam int LW  = $clog2(MAX_LEN + 1);
  localparam int SAW = scs_pkg::addr_w(MAX_LEN);
  localparam int CD  = MAX_LEN * MAX_LEN;
  localparam int CAW = scs_pkg::addr_w(CD);
  localparam int RD  = 2 * MAX_LEN;
  localparam int RAW = scs_pkg::addr_w(RD);
  localparam int RCW = $clog2(RD + 1);

  logic [LW-1:0]  len_a_r, len_a_nxt, len_b_r, len_b_nxt;
  logic           ovf_r, ovf_nxt;
  logic [LW-1:0]  i_r, i_nxt, j_r, j_nxt;
  logic [CH-1:0]  a_char_r, a_char_nxt, b_char_r, b_char_nxt;
  logic [CW-1:0]  diag_r, diag_nxt, left_r, left_nxt, cost1_r, cost1_nxt;
  logic [RCW-1:0] wcnt_r, wcnt_nxt;
  logic [RAW-1:0] rptr_r, rptr_nxt;
  logic           out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic           out_trunc_r, out_trunc_nxt;
  logic [CH-1:0]  out_char_r, out_char_nxt;

  logic [CH-1:0]  a_rd, b_rd, rev_rd, rev_wdata;
  logic [CW-1:0]  cost_rd, up_v, cell_v, left_tb;
  logic           a_we, b_we, cost_we, rev_we, tb_match, tb_left;
  logic [LW-1:0]  ri, cj;
  logic [CAW-1:0] cost_raddr, cost_waddr;

  assign a_we = (cmd.op == scs_pkg::OP_LOAD) && !in_opcode && (len_a_r < LW'(MAX_LEN));
  assign b_we = (cmd.op == scs_pkg::OP_LOAD) && in_opcode && (len_b_r < LW'(MAX_LEN));

  // cell write reads the cell above; traceback reads the corner and its left
  assign ri = (cmd.op == scs_pkg::OP_CELL_RD) ? (i_r - LW'(2)) : (i_r - LW'(1));
  assign cj = (cmd.op == scs_pkg::OP_TB_RD2) ? (j_r - LW'(2)) : (j_r - LW'(1));
  assign cost_raddr = CAW'(ri) * CAW'(MAX_LEN) + CAW'(cj);
  assign cost_waddr = CAW'(i_r - LW'(1)) * CAW'(MAX_LEN) + CAW'(j_r - LW'(1));

  assign up_v   = (i_r == LW'(1)) ? CW'(j_r) : cost_rd;
  assign cell_v = (a_char_r == b_rd) ? (diag_r + CW'(1))
                : (((up_v < left_r) ? up_v : left_r) + CW'(1));
  assign cost_we = (cmd.op == scs_pkg::OP_CELL_WR);

  assign left_tb  = (j_r == LW'(1)) ? CW'(i_r) : cost_rd;
  assign tb_match = (a_char_r == b_char_r);
  assign tb_left  = (cost1_r == left_tb + CW'(1));

  assign rev_we = (cmd.op == scs_pkg::OP_TB_DEC) || (cmd.op == scs_pkg::OP_TB_TA) ||
                  (cmd.op == scs_pkg::OP_TB_TB);
  always_comb begin
    if (cmd.op == scs_pkg::OP_TB_TA)      rev_wdata = a_rd;
    else if (cmd.op == scs_pkg::OP_TB_TB) rev_wdata = b_rd;
    else if (tb_match)                    rev_wdata = a_char_r;
    else if (tb_left)                     rev_wdata = b_char_r;
    else                                  rev_wdata = a_char_r;
  end

  scs_ram #(.W(CH), .D(MAX_LEN)) u_a_ram (
    .clk(clk), .we(a_we), .waddr(len_a_r[SAW-1:0]), .wdata(in_char_in),
    .raddr(ri[SAW-1:0]), .rdata(a_rd)
  );
  scs_ram #(.W(CH), .D(MAX_LEN)) u_b_ram (
    .clk(clk), .we(b_we), .waddr(len_b_r[SAW-1:0]), .wdata(in_char_in),
    .raddr(cj[SAW-1:0]), .rdata(b_rd)
  );
  scs_ram #(.W(CW), .D(CD)) u_cost_ram (
    .clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(cell_v),
    .raddr(cost_raddr), .rdata(cost_rd)
  );
  scs_ram #(.W(CH), .D(RD)) u_rev_ram (
    .clk(clk), .we(rev_we), .waddr(wcnt_r[RAW-1:0]), .wdata(rev_wdata),
    .raddr(rptr_r), .rdata(rev_rd)
  );

  always_comb begin
    len_a_nxt     = len_a_r;
    len_b_nxt     = len_b_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    a_char_nxt    = a_char_r;
    b_char_nxt    = b_char_r;
    diag_nxt      = diag_r;
    left_nxt      = left_r;
    cost1_nxt     = cost1_r;
    wcnt_nxt      = wcnt_r;
    rptr_nxt      = rptr_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    out_trunc_nxt = out_trunc_r;
    out_char_nxt  = out_char_r;
    unique case (cmd.op)
      scs_pkg::OP_LOAD: begin
        if (!in_opcode) begin
          if (a_we) len_a_nxt = len_a_r + LW'(1);
          else      ovf_nxt   = 1'b1;
        end else begin
          if (b_we) len_b_nxt = len_b_r + LW'(1);
          else      ovf_nxt   = 1'b1;
        end
      end
      scs_pkg::OP_START: i_nxt = LW'(1);
      scs_pkg::OP_ROW_SET: begin
        a_char_nxt = a_rd;
        diag_nxt   = CW'(i_r - LW'(1));
        left_nxt   = CW'(i_r);
        j_nxt      = LW'(1);
      end
      scs_pkg::OP_CELL_WR: begin
        diag_nxt = up_v;
        left_nxt = cell_v;
        if (j_r != len_b_r)      j_nxt = j_r + LW'(1);
        else if (i_r != len_a_r) i_nxt = i_r + LW'(1);
      end
      scs_pkg::OP_TB_INIT: begin
        i_nxt    = len_a_r;
        j_nxt    = len_b_r;
        wcnt_nxt = '0;
      end
      scs_pkg::OP_TB_RD2: begin
        cost1_nxt  = cost_rd;
        a_char_nxt = a_rd;
        b_char_nxt = b_rd;
      end
      scs_pkg::OP_TB_DEC: begin
        wcnt_nxt = wcnt_r + RCW'(1);
        if (tb_match) begin
          i_nxt = i_r - LW'(1);
          j_nxt = j_r - LW'(1);
        end else if (tb_left) begin
          j_nxt = j_r - LW'(1);
        end else begin
          i_nxt = i_r - LW'(1);
        end
      end
      scs_pkg::OP_TB_TA: begin
        i_nxt    = i_r - LW'(1);
        wcnt_nxt = wcnt_r + RCW'(1);
      end
      scs_pkg::OP_TB_TB: begin
        j_nxt    = j_r - LW'(1);
        wcnt_nxt = wcnt_r + RCW'(1);
      end
      scs_pkg::OP_OUT_INIT: rptr_nxt = RAW'(wcnt_r - RCW'(1));
      scs_pkg::OP_OUT_LD: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = rev_rd;
        out_last_nxt  = (rptr_r == '0);
        out_trunc_nxt = ovf_r;
      end
      scs_pkg::OP_OUT_POP: begin
        out_valid_nxt = 1'b0;
        if (rptr_r == '0) begin
          len_a_nxt = '0;
          len_b_nxt = '0;
          ovf_nxt   = 1'b0;
        end else begin
          rptr_nxt = rptr_r - RAW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_a_r     <= '0;
      len_b_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_a_r     <= len_a_nxt;
      len_b_r     <= len_b_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    a_char_r    <= a_char_nxt;
    b_char_r    <= b_char_nxt;
    diag_r      <= diag_nxt;
    left_r      <= left_nxt;
    cost1_r     <= cost1_nxt;
    wcnt_r      <= wcnt_nxt;
    rptr_r      <= rptr_nxt;
    out_last_r  <= out_last_nxt;
    out_trunc_r <= out_trunc_nxt;
    out_char_r  <= out_char_nxt;
  end

  assign sts.empty     = (len_a_r == '0) || (len_b_r == '0);
  assign sts.row_last  = (j_r == len_b_r);
  assign sts.tab_last  = (i_r == len_a_r);
  assign sts.i_nz      = (i_r != '0);
  assign sts.j_nz      = (j_r != '0);
  assign sts.rptr_zero = (rptr_r == '0);

  assign out_valid     = out_valid_r;
  assign out_char_out  = out_char_r;
  assign out_last      = out_last_r;
  assign out_truncated = out_trunc_r;

  `SCS_ASSERT(a_len_bound, clk, rst_n, (len_a_r <= LW'(MAX_LEN)) && (len_b_r <= LW'(MAX_LEN)))
  `SCS_ASSERT_IMP(a_cell_bound, clk, rst_n, cmd.op == scs_pkg::OP_CELL_WR, cell_v <= CW'(i_r) + CW'(j_r))
  `SCS_ASSERT_NXT(a_pair_clear, clk, rst_n, (cmd.op == scs_pkg::OP_OUT_POP) && (rptr_r == '0), (len_a_r == '0) && (len_b_r == '0) && !ovf_r)
endmodule

>>> src/shortest_common_supersequence.sv
// top level of the shortest common supersequence block
//
//   channel | ports                                            | direction
//   --------+--------------------------------------------------+----------
//   in      | in_valid, in_stall, in_opcode, in_char_in,       | input beat
//           | in_end_of_pair                                   |
//   out     | out_valid, out_stall, out_char_out, out_last,    | result beat
//           | out_truncated                                    |
//
// loads one input beat per cycle while idle; the end beat starts the fill
// fill: row_rd and row_set per row, then cell_rd and cell_wr per cell,
//   each cell split in two by the single read port of the cost table ram
// traceback: per character tb_chk, then tb_rd2/tb_dec, tb_ta or tb_tb;
//   then per result beat out_rd, out_ld and out_wait, held by out_stall
// reset is synchronous on rst_n; the string and table rams are not cleared
// in_stall stays high from the end beat until the last result beat is taken
module shortest_common_supersequence #(
  parameter int MAX_LEN = scs_pkg::MAX_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input beats, one character each
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_opcode,
  input  logic [scs_pkg::CHAR_W-1:0] in_char_in,
  input  logic                       in_end_of_pair,
  // result beats, supersequence front to back
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [scs_pkg::CHAR_W-1:0] out_char_out,
  output logic                       out_last,
  output logic                       out_truncated
);
  // command and status between the sequencer and the datapath
  scs_pkg::cmd_t cmd;
  scs_pkg::sts_t sts;

  // sequencer: load, fill, traceback, drain
  scs_ctrl u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_end_of_pair(in_end_of_pair),
    .in_stall(in_stall),
    .out_stall(out_stall),
    .sts(sts),
    .cmd(cmd)
  );

  // datapath holds the strings, the cost table and the reversed result
  scs_dp #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .sts(sts),
    .in_opcode(in_opcode),
    .in_char_in(in_char_in),
    .out_valid(out_valid),
    .out_char_out(out_char_out),
    .out_last(out_last),
    .out_truncated(out_truncated)
  );
endmodule

>>> dv/shortest_common_supersequence_test.sv
// testbench of the shortest common supersequence block: predicted beats checked in order
class scs_scoreboard;
  logic [7:0] first_q[$];
  logic [7:0] second_q[$];
  bit         overflow;
  logic [7:0] exp_char[$];
  logic       exp_last[$];
  logic       exp_trunc[$];
  int         errors;

  function void note_input(logic op, logic [7:0] ch, logic endp);
    int n, m, i, j, k;
    logic [6:0] cost[0:32][0:32];
    logic [7:0] rev[$];
    if (!op) begin
      if (first_q.size() < 32) first_q.push_back(ch); else overflow = 1;
    end else begin
      if (second_q.size() < 32) second_q.push_back(ch); else overflow = 1;
    end
    if (!endp) return;
    n = first_q.size();
    m = second_q.size();
    for (i = 0; i <= n; i++) cost[i][0] = i;
    for (j = 0; j <= m; j++) cost[0][j] = j;
    for (i = 1; i <= n; i++)
      for (j = 1; j <= m; j++)
        if (first_q[i-1] == second_q[j-1]) cost[i][j] = cost[i-1][j-1] + 1;
        else if (cost[i-1][j] < cost[i][j-1]) cost[i][j] = cost[i-1][j] + 1;
        else cost[i][j] = cost[i][j-1] + 1;
    i = n;
    j = m;
    // trace back from the corner, collecting the supersequence in reverse
    while (i > 0 && j > 0) begin
      if (first_q[i-1] == second_q[j-1]) begin
        rev.push_back(first_q[i-1]);
        i--;
        j--;
      end else if (cost[i][j] - 7'd1 == cost[i][j-1]) begin
        rev.push_back(second_q[j-1]);
        j--;
      end else begin
        rev.push_back(first_q[i-1]);
        i--;
      end
    end
    while (i > 0) begin rev.push_back(first_q[i-1]); i--; end
    while (j > 0) begin rev.push_back(second_q[j-1]); j--; end
    for (k = rev.size() - 1; k >= 0; k--) begin
      exp_char.push_back(rev[k]);
      exp_last.push_back(k == 0);
      exp_trunc.push_back(overflow);
    end
    first_q.delete();
    second_q.delete();
    overflow = 0;
  endfunction

  function void report(string what);
    $display("mismatch: %s", what);
    errors++;
  endfunction

  function void check_result(logic [7:0] ch, logic lst, logic tr);
    logic [7:0] ec;
    logic el, et;
    if (exp_char.size() == 0) begin
      report($sformatf("unexpected beat char %h", ch));
      return;
    end
    ec = exp_char.pop_front();
    el = exp_last.pop_front();
    et = exp_trunc.pop_front();
    if (ch !== ec) report($sformatf("char_out %h expected %h", ch, ec));
    if (lst !== el) report($sformatf("last %b expected %b", lst, el));
    if (tr !== et) report($sformatf("truncated %b expected %b", tr, et));
  endfunction

  function int pending();
    return exp_char.size();
  endfunction
endclass

module shortest_common_supersequence_test;
  logic       clk = 0;
  logic       rst_n = 0;
  logic       in_valid = 0;
  logic       in_stall;
  logic       in_opcode = 0;
  logic [7:0] in_char_in = 0;
  logic       in_end_of_pair = 0;
  logic       out_valid;
  logic       out_stall = 1;
  logic [7:0] out_char_out;
  logic       out_last;
  logic       out_truncated;

  scs_scoreboard sb = new();
  int cycles = 0;
  int out_wait = 0;

  shortest_common_supersequence dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // generous limit: pairs are mostly short, a few near or past full 32x32 size
  always @(posedge clk) begin
    cycles++;
    if (cycles > 1500000) begin
      $display("shortest_common_supersequence_test NOT OK");
      $finish;
    end
  end

  // result side: sample at the rising edge, draw a fresh wait per beat
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_char_out, out_last, out_truncated);
      out_wait = $urandom_range(0, 4);
    end
  end
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1;
    else if (out_wait > 0) begin
      out_stall <= 1;
      out_wait--;
    end else begin
      out_stall <= 0;
    end
  end

  bit burst;

  // one input beat: optional idle gap, then hold valid until accepted
  task send_beat(logic op, logic [7:0] ch, logic endp);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_opcode <= op;
    in_char_in <= ch;
    in_end_of_pair <= endp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(op, ch, endp);
    @(negedge clk);
  endtask

  task idle_in();
    in_valid <= 0;
  endtask

  // a full pair; alpha below 256 narrows the alphabet so matches are common
  task send_pair(int n, int m, int alpha);
    int a, b, t;
    logic [7:0] ch;
    a = 0;
    b = 0;
    t = n + m;
    while (a + b < t) begin
      if (b >= m || (a < n && $urandom_range(0, 1))) begin
        ch = (alpha >= 256) ? $urandom_range(0, 255) : 8'h61 + $urandom_range(0, alpha - 1);
        a++;
        send_beat(0, ch, (a + b == t));
      end else begin
        ch = (alpha >= 256) ? $urandom_range(0, 255) : 8'h61 + $urandom_range(0, alpha - 1);
        b++;
        send_beat(1, ch, (a + b == t));
      end
    end
  endtask

  task wait_drain();
    idle_in();
    while (sb.pending() > 0) @(negedge clk);
  endtask

  initial begin
    int p, n, m;
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: extremes of char, both opcodes, end on either opcode
    burst = 0;
    send_beat(0, 8'h00, 0);
    send_beat(1, 8'hff, 1);
    send_beat(1, 8'h55, 0);
    send_beat(0, 8'haa, 1);      // end carried by a first-string beat
    send_beat(1, 8'h7f, 1);      // first string empty
    send_beat(0, 8'h80, 1);      // second string empty
    send_beat(0, 8'h41, 0);
    send_beat(1, 8'h41, 1);      // single match
    wait_drain();                // sender holds off until all results are in
    // overflow: 33 chars into the first string, end on the dropped one
    burst = 1;
    send_pair(32, 1, 3);
    for (p = 0; p < 32; p++) send_beat(0, $urandom_range(0, 255), 0);
    send_beat(0, 8'h12, 1);      // dropped character on end beat
    burst = 0;
    // random pairs, mostly short, a few near or past full size
    p = 0;
    while (p < 280) begin
      burst = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 15) == 0) begin
        n = 32 + $urandom_range(0, 2);
        m = $urandom_range(28, 34);
      end else begin
        n = $urandom_range(0, 6);
        m = $urandom_range(0, 6);
        if (n + m == 0) n = 1;
      end
      send_pair(n, m, ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 4));
      p += n + m;
    end
    idle_in();
    while (sb.pending() > 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (sb.errors == 0) $display("shortest_common_supersequence_test OK");
    else $display("shortest_common_supersequence_test NOT OK");
    $finish;
  end
endmodule
